/* hw/rtl/hrfc_pkg.sv */
// Package for the hex response frame checker: frame constants, register
// indexes, status codes, result and config structs, hex digit decode.
// No dependencies.
`default_nettype none

package hrfc_pkg;

   localparam logic [7:0] OPEN_CHAR      = 8'h5B;
   localparam logic [7:0] CLOSE_CHAR     = 8'h5D;
   localparam logic [7:0] FRAME_OVERHEAD = 8'd8;
   localparam logic [7:0] MAX_PAYLOAD    = 8'd247;

   localparam logic [7:0] REG_PAYLOAD_LENGTH   = 8'd0;
   localparam logic [7:0] REG_ECHO_FIRST_CHAR  = 8'd1;
   localparam logic [7:0] REG_ECHO_SECOND_CHAR = 8'd2;

   localparam logic [7:0] RESET_ECHO_CHAR = 8'h30;

   typedef enum logic [2:0] {
      STATUS_OK       = 3'd0,
      STATUS_LENGTH   = 3'd1,
      STATUS_BRACKETS = 3'd2,
      STATUS_ECHO     = 3'd3,
      STATUS_CHECKSUM = 3'd4
   } status_type;

   typedef struct packed {
      logic [7:0] payload_length;
      logic [7:0] echo_first_char;
      logic [7:0] echo_second_char;
   } cfg_type;

   typedef struct packed {
      logic       payload_valid;
      logic [7:0] payload_char;
      logic       frame_done;
      status_type frame_status;
   } result_type;

   // 0..15 for a hex digit, bit 4 set otherwise
   function automatic logic [4:0] hex_value(input logic [7:0] c);
      logic [4:0] v;
      v = 5'h10;
      if (c >= 8'h30 && c <= 8'h39) begin
         v = {1'b0, c[3:0]};
      end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
         v = {1'b0, c[3:0] + 4'd9};
      end
      return v;
   endfunction

   function automatic logic field_mismatch(input logic [4:0] hi,
                                           input logic [7:0] low_char,
                                           input logic [7:0] expect_val);
      logic [4:0] lo;
      lo = hex_value(low_char);
      return hi[4] | lo[4] | ({hi[3:0], lo[3:0]} != expect_val);
   endfunction

endpackage

`default_nettype wire

/* hw/rtl/hrfc_channels.sv */
// Channel interfaces for the hex response frame checker: character input,
// result output and register write port. No dependencies.
`default_nettype none

interface hrfc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_char;
   modport source (output valid, output rx_char, input ready);
   modport sink   (input valid, input rx_char, output ready);
endinterface

interface hrfc_rsp_if;
   logic       valid;
   logic       ready;
   logic       payload_valid;
   logic [7:0] payload_char;
   logic       frame_done;
   logic [2:0] frame_status;
   modport source (output valid, output payload_valid, output payload_char,
                   output frame_done, output frame_status, input ready);
   modport sink   (input valid, input payload_valid, input payload_char,
                   input frame_done, input frame_status, output ready);
endinterface

interface hrfc_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] index;
   logic [7:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* hw/rtl/hex_response_frame_checker.sv */
// Top level of the hex response frame checker: register file, frame core
// and result register. Depends on hrfc_pkg, hrfc_channels, hrfc_frame_core.
//
//   channel  interface    role   contents
//   req_if   hrfc_req_if  sink   rx_char, one character per transfer
//   rsp_if   hrfc_rsp_if  source payload_valid, payload_char, frame_done, frame_status
//   csr_if   hrfc_csr_if  sink   index, data (register write, always ready)
//
// One result per character, one character per cycle while req_if.ready is high; each
// result is registered and valid in the cycle after its take. req_if.ready is high
// while the result register is empty or being taken in the same cycle. Synchronous
// active-high reset clears frame state and registers (echo characters reset to '0').
`default_nettype none

module hex_response_frame_checker (
   input wire logic clock,
   input wire logic reset,
   hrfc_req_if.sink   req_if,
   hrfc_rsp_if.source rsp_if,
   hrfc_csr_if.sink   csr_if
);

   hrfc_pkg::cfg_type    cfg_ff, cfg_in;
   hrfc_pkg::result_type result;
   hrfc_pkg::result_type rsp_data_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 req_ready;
   logic                 take;

   assign csr_if.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_if.valid) begin
         case (csr_if.index)
            hrfc_pkg::REG_PAYLOAD_LENGTH:   cfg_in.payload_length   = csr_if.data;
            hrfc_pkg::REG_ECHO_FIRST_CHAR:  cfg_in.echo_first_char  = csr_if.data;
            hrfc_pkg::REG_ECHO_SECOND_CHAR: cfg_in.echo_second_char = csr_if.data;
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.payload_length   <= 8'd0;
         cfg_ff.echo_first_char  <= hrfc_pkg::RESET_ECHO_CHAR;
         cfg_ff.echo_second_char <= hrfc_pkg::RESET_ECHO_CHAR;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_ready    = !rsp_valid_ff || rsp_if.ready;
   assign req_if.ready = req_ready;
   assign take         = req_if.valid && req_ready;

   hrfc_frame_core u_core (
      .clock   (clock),
      .reset   (reset),
      .take    (take),
      .rx_char (req_if.rx_char),
      .cfg     (cfg_ff),
      .result  (result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.payload_valid = rsp_data_ff.payload_valid;
   assign rsp_if.payload_char  = rsp_data_ff.payload_char;
   assign rsp_if.frame_done    = rsp_data_ff.frame_done;
   assign rsp_if.frame_status  = rsp_data_ff.frame_status;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_if.ready) |-> !take)
      else $error("result register overwritten while stalled");

   a_take_loads: assert property (@(posedge clock) disable iff (reset)
      take |=> rsp_valid_ff)
      else $error("accepted character produced no result");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_if.ready) |=> (rsp_valid_ff && $stable(rsp_data_ff)))
      else $error("stalled result changed or dropped");

endmodule

`default_nettype wire

/* hw/rtl/hrfc_frame_core.sv */
// Frame tracking for the hex response frame checker: position, running sum,
// sticky check flags and per-character result. Depends on hrfc_pkg.
`default_nettype none

module hrfc_frame_core (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                take,
   input  wire logic [7:0]          rx_char,
   input  wire hrfc_pkg::cfg_type   cfg,
   output      hrfc_pkg::result_type result
);

   logic [7:0] pos_ff, pos_in;
   logic [7:0] sum_ff, sum_in;
   logic [4:0] high_ff, high_in;
   logic       len_err_ff, len_err_in;
   logic       brk_err_ff, brk_err_in;
   logic       echo_err_ff, echo_err_in;

   logic [7:0] plen;
   logic [7:0] size;
   logic [7:0] chk_hi_pos;
   logic [7:0] chk_lo_pos;

   always_comb begin
      plen       = (cfg.payload_length > hrfc_pkg::MAX_PAYLOAD) ?
                   hrfc_pkg::MAX_PAYLOAD : cfg.payload_length;
      size       = plen + hrfc_pkg::FRAME_OVERHEAD;
      chk_hi_pos = size - 8'd3;
      chk_lo_pos = size - 8'd2;
   end

   always_comb begin
      sum_in      = sum_ff;
      high_in     = high_ff;
      len_err_in  = len_err_ff;
      brk_err_in  = brk_err_ff;
      echo_err_in = echo_err_ff;
      pos_in      = pos_ff + 8'd1;
      result.payload_valid = 1'b0;
      result.payload_char  = 8'd0;
      result.frame_done    = 1'b0;
      result.frame_status  = hrfc_pkg::STATUS_OK;

      if (pos_ff >= 8'd1 && pos_ff < chk_hi_pos) begin
         sum_in = sum_ff + rx_char;
      end

      if (pos_ff == 8'd0) begin
         if (rx_char != hrfc_pkg::OPEN_CHAR) begin
            brk_err_in = 1'b1;
         end
      end else if (pos_ff == 8'd1 || pos_ff == chk_hi_pos) begin
         high_in = hrfc_pkg::hex_value(rx_char);
      end else if (pos_ff == 8'd2) begin
         if (hrfc_pkg::field_mismatch(high_ff, rx_char, size)) begin
            len_err_in = 1'b1;
         end
      end else if (pos_ff == 8'd3) begin
         if (rx_char != cfg.echo_first_char) begin
            echo_err_in = 1'b1;
         end
      end else if (pos_ff == 8'd4) begin
         if (rx_char != cfg.echo_second_char) begin
            echo_err_in = 1'b1;
         end
      end else if (pos_ff < chk_hi_pos) begin
         result.payload_valid = 1'b1;
         result.payload_char  = rx_char;
      end else if (pos_ff == chk_lo_pos) begin
         high_in = {4'd0, hrfc_pkg::field_mismatch(high_ff, rx_char, sum_ff)};
      end else begin
         result.frame_done = 1'b1;
         if (len_err_ff) begin
            result.frame_status = hrfc_pkg::STATUS_LENGTH;
         end else if (brk_err_ff || rx_char != hrfc_pkg::CLOSE_CHAR) begin
            result.frame_status = hrfc_pkg::STATUS_BRACKETS;
         end else if (echo_err_ff) begin
            result.frame_status = hrfc_pkg::STATUS_ECHO;
         end else if (high_ff[0]) begin
            result.frame_status = hrfc_pkg::STATUS_CHECKSUM;
         end
         pos_in      = 8'd0;
         sum_in      = 8'd0;
         high_in     = 5'd0;
         len_err_in  = 1'b0;
         brk_err_in  = 1'b0;
         echo_err_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= 8'd0;
         sum_ff      <= 8'd0;
         high_ff     <= 5'd0;
         len_err_ff  <= 1'b0;
         brk_err_ff  <= 1'b0;
         echo_err_ff <= 1'b0;
      end else if (take) begin
         pos_ff      <= pos_in;
         sum_ff      <= sum_in;
         high_ff     <= high_in;
         len_err_ff  <= len_err_in;
         brk_err_ff  <= brk_err_in;
         echo_err_ff <= echo_err_in;
      end
   end

   a_done_clears: assert property (@(posedge clock) disable iff (reset)
      (take && result.frame_done) |=>
         (pos_ff == 8'd0 && sum_ff == 8'd0 && !len_err_ff && !brk_err_ff && !echo_err_ff))
      else $error("frame state not cleared after frame end");

   a_status_only_at_end: assert property (@(posedge clock) disable iff (reset)
      !result.frame_done |-> result.frame_status == hrfc_pkg::STATUS_OK)
      else $error("status reported before frame end");

   a_payload_not_end: assert property (@(posedge clock) disable iff (reset)
      result.payload_valid |-> (!result.frame_done && pos_ff >= 8'd5))
      else $error("payload flagged outside payload section");

   a_pos_advances: assert property (@(posedge clock) disable iff (reset)
      (take && !result.frame_done) |=> pos_ff == $past(pos_ff) + 8'd1)
      else $error("position did not advance");

endmodule

`default_nettype wire

/* test/tb_hex_response_frame_checker.sv */
// Testbench for hex_response_frame_checker: drives character transfers, predicts
// each result in a local frame model and compares every result field by field.
// Depends on hrfc_pkg, hrfc_channels and the RTL top level.
`timescale 1ns / 1ps

module tb_hex_response_frame_checker;
   import hrfc_pkg::*;

   localparam int unsigned HOLD_CYCLES = 300;

   logic clock;
   logic reset;

   hrfc_req_if req_if();
   hrfc_rsp_if rsp_if();
   hrfc_csr_if csr_if();

   hex_response_frame_checker i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   // frame model state and register copy
   cfg_type    frame_cfg = '{payload_length: 8'd0, echo_first_char: RESET_ECHO_CHAR,
                             echo_second_char: RESET_ECHO_CHAR};
   logic [7:0] frame_pos   = '0;
   logic [7:0] cksum_acc   = '0;
   logic [4:0] held_digit  = '0;
   logic       len_bad     = 1'b0;
   logic       bracket_bad = 1'b0;
   logic       echo_bad    = 1'b0;

   result_type  expected_results[$];
   int unsigned errors     = 0;
   int unsigned chars_sent = 0;
   int unsigned idle_pct   = 0;
   int unsigned stall_pct  = 0;
   int unsigned hold_asked = 0;
   int unsigned hold_taken = 0;
   int unsigned hold_left  = 0;
   bit          req_offering = 1'b0;
   bit          csr_offering = 1'b0;

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      if (c >= "0" && c <= "9") return 5'(c - "0");
      if (c >= "A" && c <= "F") return 5'(c - "A" + 8'd10);
      if (c >= "a" && c <= "f") return 5'(c - "a" + 8'd10);
      return 5'h10;
   endfunction

   function automatic logic field_differs(input logic [4:0] hi, input logic [7:0] lo_char,
                                          input logic [7:0] want);
      logic [4:0] lo;
      lo = hex_digit(lo_char);
      if (hi[4] || lo[4]) return 1'b1;
      return {hi[3:0], lo[3:0]} != want;
   endfunction

   function automatic logic [7:0] frame_length();
      return ((frame_cfg.payload_length > MAX_PAYLOAD) ? MAX_PAYLOAD
              : frame_cfg.payload_length) + FRAME_OVERHEAD;
   endfunction

   function automatic result_type predict_char(input logic [7:0] c);
      logic [7:0] flen;
      logic [7:0] pos;
      result_type r;
      flen = frame_length();
      pos = frame_pos;
      r = '0;
      r.frame_status = STATUS_OK;
      if (pos >= 8'd1 && pos < flen - 8'd3) cksum_acc = cksum_acc + c;
      if (pos == 8'd0) begin
         if (c != OPEN_CHAR) bracket_bad = 1'b1;
      end else if (pos == 8'd1 || pos == flen - 8'd3) begin
         held_digit = hex_digit(c);
      end else if (pos == 8'd2) begin
         if (field_differs(held_digit, c, flen)) len_bad = 1'b1;
      end else if (pos == 8'd3) begin
         if (c != frame_cfg.echo_first_char) echo_bad = 1'b1;
      end else if (pos == 8'd4) begin
         if (c != frame_cfg.echo_second_char) echo_bad = 1'b1;
      end else if (pos < flen - 8'd3) begin
         r.payload_valid = 1'b1;
         r.payload_char = c;
      end else if (pos == flen - 8'd2) begin
         held_digit = {4'b0, field_differs(held_digit, c, cksum_acc)};
      end else begin
         if (c != CLOSE_CHAR) bracket_bad = 1'b1;
         r.frame_done = 1'b1;
         if (len_bad) r.frame_status = STATUS_LENGTH;
         else if (bracket_bad) r.frame_status = STATUS_BRACKETS;
         else if (echo_bad) r.frame_status = STATUS_ECHO;
         else if (held_digit[0]) r.frame_status = STATUS_CHECKSUM;
      end
      if (r.frame_done) begin
         frame_pos = '0;
         cksum_acc = '0;
         held_digit = '0;
         len_bad = 1'b0;
         bracket_bad = 1'b0;
         echo_bad = 1'b0;
      end else begin
         frame_pos = pos + 8'd1;
      end
      return r;
   endfunction

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
         errors++;
      end
   endfunction

   always @(posedge clock) begin : check_results
      result_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_results.size() == 0) begin
            $display("%0t: result transfer with nothing pending, expected none actual %h",
                     $time, {rsp_if.payload_valid, rsp_if.payload_char,
                             rsp_if.frame_done, rsp_if.frame_status});
            errors++;
         end else begin
            want = expected_results.pop_front();
            check_field("payload_valid", want.payload_valid, rsp_if.payload_valid);
            check_field("payload_char", want.payload_char, rsp_if.payload_char);
            check_field("frame_done", want.frame_done, rsp_if.frame_done);
            check_field("frame_status", want.frame_status, rsp_if.frame_status);
         end
      end
   end

   // result side: random stalls plus an occasional long hold-off
   initial begin
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left != 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else if (hold_taken != hold_asked) begin
            hold_taken = hold_asked;
            hold_left = HOLD_CYCLES;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= ($urandom_range(0, 99) >= stall_pct);
         end
      end
   end

   task automatic drop_req();
      if (req_offering) begin
         req_if.valid <= 1'b0;
         req_offering = 1'b0;
      end
   endtask

   task automatic drop_csr();
      if (csr_offering) begin
         csr_if.valid <= 1'b0;
         csr_offering = 1'b0;
      end
   endtask

   task automatic send_char(input logic [7:0] c);
      drop_csr();
      while ($urandom_range(0, 99) < idle_pct) begin
         drop_req();
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.rx_char <= c;
      req_offering = 1'b1;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      expected_results.push_back(predict_char(c));
      chars_sent++;
   endtask

   task automatic wait_until_answered();
      drop_req();
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [7:0] idx, input logic [7:0] val);
      wait_until_answered();
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data <= val;
      csr_offering = 1'b1;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      case (idx)
         REG_PAYLOAD_LENGTH:   frame_cfg.payload_length = val;
         REG_ECHO_FIRST_CHAR:  frame_cfg.echo_first_char = val;
         REG_ECHO_SECOND_CHAR: frame_cfg.echo_second_char = val;
         default: ;
      endcase
   endtask

   task automatic send_text(input string s);
      for (int k = 0; k < s.len(); k++) send_char(s[k]);
   endtask

   function automatic logic [7:0] hex_ascii(input logic [3:0] n);
      if (n < 4'd10) return 8'h30 + n;
      return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + n - 8'd10;
   endfunction

   // two hex characters for v; corrupt gives a wrong value or a non-hex digit
   function automatic logic [15:0] field_text(input logic [7:0] v, input bit corrupt);
      logic [7:0]  f;
      logic [7:0]  junk;
      logic [4:0]  d;
      logic [15:0] txt;
      f = v;
      if (corrupt && $urandom_range(0, 1)) f = v ^ 8'($urandom_range(1, 255));
      txt = {hex_ascii(f[7:4]), hex_ascii(f[3:0])};
      if (corrupt && f == v) begin
         do begin
            junk = 8'($urandom_range(0, 255));
            d = hex_digit(junk);
         end while (!d[4]);
         if ($urandom_range(0, 1)) txt[15:8] = junk;
         else txt[7:0] = junk;
      end
      return txt;
   endfunction

   // faults: open bracket, length, echo, checksum, close bracket
   task automatic send_frame(input logic [4:0] faults);
      logic [7:0]  chars[$];
      logic [7:0]  sum;
      logic [15:0] txt;
      int unsigned echo_hit;
      chars.push_back(faults[0] ? OPEN_CHAR ^ 8'($urandom_range(1, 255)) : OPEN_CHAR);
      txt = field_text(frame_length(), faults[1]);
      chars.push_back(txt[15:8]);
      chars.push_back(txt[7:0]);
      echo_hit = faults[2] ? $urandom_range(1, 3) : 0;
      chars.push_back(frame_cfg.echo_first_char
                      ^ (echo_hit[0] ? 8'($urandom_range(1, 255)) : 8'd0));
      chars.push_back(frame_cfg.echo_second_char
                      ^ (echo_hit[1] ? 8'($urandom_range(1, 255)) : 8'd0));
      repeat (frame_length() - FRAME_OVERHEAD) chars.push_back(8'($urandom_range(0, 255)));
      sum = '0;
      for (int k = 1; k < chars.size(); k++) sum = sum + chars[k];
      txt = field_text(sum, faults[3]);
      chars.push_back(txt[15:8]);
      chars.push_back(txt[7:0]);
      chars.push_back(faults[4] ? CLOSE_CHAR ^ 8'($urandom_range(1, 255)) : CLOSE_CHAR);
      foreach (chars[j]) send_char(chars[j]);
   endtask

   task automatic send_noise();
      repeat ($urandom_range(1, 12)) send_char(8'($urandom_range(0, 255)));
      while (frame_pos != 8'd0) send_char(8'($urandom_range(0, 255)));
   endtask

   task automatic pick_config();
      int unsigned r;
      logic [7:0]  plen;
      r = $urandom_range(0, 99);
      if (r < 15) plen = 8'd0;
      else if (r < 85) plen = 8'($urandom_range(1, 8));
      else plen = 8'($urandom_range(9, 30));
      write_reg(REG_PAYLOAD_LENGTH, plen);
      write_reg(REG_ECHO_FIRST_CHAR, 8'($urandom_range(0, 255)));
      write_reg(REG_ECHO_SECOND_CHAR, 8'($urandom_range(0, 255)));
   endtask

   task automatic test_reset_defaults();
      send_text("[0800c8]");
      wait_until_answered();
   endtask

   // every check fails at once: the length field must win
   task automatic test_error_priority();
      write_reg(REG_PAYLOAD_LENGTH, 8'd1);
      write_reg(REG_ECHO_FIRST_CHAR, 8'hFF);
      write_reg(REG_ECHO_SECOND_CHAR, 8'h00);
      send_text("{0G");
      send_char(8'h00);
      send_char(8'hFF);
      send_text("Zzz)");
      wait_until_answered();
   endtask

   // shrink the frame under a partly received one so it ends past its last position
   task automatic test_register_change();
      write_reg(REG_PAYLOAD_LENGTH, 8'd3);
      send_text("[0B");
      send_char(8'hFF);
      send_char(8'h00);
      send_text("abcz");
      write_reg(REG_PAYLOAD_LENGTH, 8'd0);
      send_text("]");
      wait_until_answered();
   endtask

   task automatic test_random_frames(input int unsigned idle, input int unsigned stall,
                                     input int unsigned budget);
      int unsigned start_count;
      int unsigned frames;
      int unsigned r;
      idle_pct = idle;
      stall_pct <= stall;
      start_count = chars_sent;
      frames = 0;
      while (chars_sent - start_count < budget) begin
         if (frames % 6 == 0) pick_config();
         r = $urandom_range(0, 99);
         if (r < 65) send_frame(5'd0);
         else if (r < 90) send_frame(5'($urandom_range(1, 31)));
         else send_noise();
         frames++;
      end
      wait_until_answered();
   endtask

   task automatic test_backpressure_hold();
      idle_pct = 0;
      stall_pct <= 0;
      pick_config();
      hold_asked <= hold_asked + 1;
      repeat (3) send_frame(5'd0);
      wait_until_answered();
   endtask

   task automatic test_longest_frames();
      idle_pct = 13;
      stall_pct <= 13;
      write_reg(REG_PAYLOAD_LENGTH, 8'd255);
      send_frame(5'd0);
      write_reg(REG_PAYLOAD_LENGTH, MAX_PAYLOAD);
      send_frame(5'b01000);
      write_reg(REG_PAYLOAD_LENGTH, 8'd4);
      wait_until_answered();
   endtask

   initial begin
      int unsigned wait_cycles;
      reset <= 1'b1;
      req_if.valid <= 1'b0;
      req_if.rx_char <= '0;
      csr_if.valid <= 1'b0;
      csr_if.index <= '0;
      csr_if.data <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_error_priority();
      test_register_change();
      test_random_frames(0, 0, 50);
      test_random_frames(68, 0, 50);
      test_random_frames(0, 68, 50);
      test_random_frames(13, 13, 50);
      test_backpressure_hold();
      test_longest_frames();

      drop_req();
      drop_csr();
      wait_cycles = 0;
      while (expected_results.size() != 0 && wait_cycles < 1000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (4) @(posedge clock);
      if (expected_results.size() != 0) begin
         $display("%0t: results pending at end, expected 0 actual %0d", $time,
                  expected_results.size());
         errors++;
      end
      if (errors == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
